FILE: rtl/psl_pkg.sv
// ----------------------------------------------------------------------------
// PI speed loop package
// Shared types, register indexes and reset constants for the PI speed loop.
// ----------------------------------------------------------------------------
package psl_pkg;

   localparam int unsigned DUTY_MAX_DEF = 65535;

   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned ADDR_W = 5;

   localparam logic [31:0] PROP_GAIN_RST     = 32'd98304000;
   localparam logic [31:0] INTEG_GAIN_RST    = 32'd0;
   localparam logic [30:0] INTEG_LIMIT_RST   = 31'h7FFF_FFFF;
   localparam logic [31:0] SPEED_SCALE_RST   = 32'd1280;
   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_INTEG_GAIN    = 3'd1,
      CSR_INTEG_LIMIT   = 3'd2,
      CSR_SPEED_SCALE   = 3'd3,
      CSR_SAMPLE_PERIOD = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAS,
      ST_ERR,
      ST_INC,
      ST_ACC,
      ST_INTEG,
      ST_SUM,
      ST_FIN
   } seq_state_type;

   typedef struct packed {
      logic [31:0] prop_gain;
      logic [31:0] integ_gain;
      logic [30:0] integ_limit;
      logic [31:0] speed_scale;
      logic [15:0] sample_period;
   } csr_regs_type;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_op_type;

   typedef struct packed {
      logic        load;
      logic [15:0] duty_fwd;
      logic [15:0] duty_rev;
      logic        saturated;
   } psl_result_type;

endpackage

FILE: rtl/psl_mul.sv
// ----------------------------------------------------------------------------
// PI speed loop shared multiplier
// One signed 33 x 33 multiplier with a registered product, shared by the product steps.
// ----------------------------------------------------------------------------
module psl_mul (
   input  logic                                 clock,
   input  psl_pkg::mul_op_type                  op,
   output logic signed [psl_pkg::PROD_W-1:0]    prod_ff
);
   import psl_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = $signed(op.a) * $signed(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/psl_csr.sv
// ----------------------------------------------------------------------------
// PI speed loop register file
// Gain, clamp, scale and period registers behind a simple peripheral port.
// ----------------------------------------------------------------------------
module psl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [psl_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output psl_pkg::csr_regs_type         regs
);
   import psl_pkg::*;

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign regs       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            CSR_PROP_GAIN:     regs_in.prop_gain     = csr_pwdata;
            CSR_INTEG_GAIN:    regs_in.integ_gain    = csr_pwdata;
            CSR_INTEG_LIMIT:   regs_in.integ_limit   = csr_pwdata[30:0];
            CSR_SPEED_SCALE:   regs_in.speed_scale   = csr_pwdata;
            CSR_SAMPLE_PERIOD: regs_in.sample_period = csr_pwdata[15:0];
            default:           regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_PROP_GAIN:     csr_prdata = regs_ff.prop_gain;
         CSR_INTEG_GAIN:    csr_prdata = regs_ff.integ_gain;
         CSR_INTEG_LIMIT:   csr_prdata = {1'b0, regs_ff.integ_limit};
         CSR_SPEED_SCALE:   csr_prdata = regs_ff.speed_scale;
         CSR_SAMPLE_PERIOD: csr_prdata = {16'd0, regs_ff.sample_period};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.prop_gain     <= PROP_GAIN_RST;
         regs_ff.integ_gain    <= INTEG_GAIN_RST;
         regs_ff.integ_limit   <= INTEG_LIMIT_RST;
         regs_ff.speed_scale   <= SPEED_SCALE_RST;
         regs_ff.sample_period <= SAMPLE_PERIOD_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

FILE: rtl/psl_seq.sv
// ----------------------------------------------------------------------------
// PI speed loop sequencer
// Steps one item through error, integral and drive using the shared multiplier.
// ----------------------------------------------------------------------------
module psl_seq #(
   parameter int unsigned DUTY_MAX = psl_pkg::DUTY_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          target_speed,
   input  logic [15:0]                          encoder_delta,
   input  logic                                 out_free,
   input  psl_pkg::csr_regs_type                regs,
   output psl_pkg::mul_op_type                  mul_op,
   input  logic signed [psl_pkg::PROD_W-1:0]    prod,
   output psl_pkg::psl_result_type              result
);
   import psl_pkg::*;

   seq_state_type      state_ff;
   seq_state_type      state_in;

   logic signed [31:0] target_ff;
   logic signed [15:0] delta_ff;
   logic signed [31:0] err_ff;
   logic signed [31:0] err_in;
   logic signed [31:0] integ_ff;
   logic signed [31:0] integ_in;
   logic signed [64:0] p1_ff;
   logic signed [64:0] sum_ff;

   logic               ld_in;
   logic               ld_err;
   logic               ld_acc;
   logic               ld_p1;
   logic               ld_sum;
   logic               load_out;

   logic signed [48:0] diff;
   logic signed [47:0] inc_prod;
   logic signed [47:0] inc_adj;
   logic signed [33:0] acc_sum;
   logic signed [33:0] lim;
   logic signed [33:0] acc_clamp;
   logic signed [64:0] adj_sum;
   logic signed [33:0] drive;
   logic        [33:0] mag;
   logic               sat;
   logic        [15:0] duty;

   function automatic logic signed [64:0] halve(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] t;
      t = x + $signed({{(PROD_W-1){1'b0}}, x[PROD_W-1]});
      return t[PROD_W-1:1];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign ld_in     = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MEAS;
         ST_MEAS:  state_in = ST_ERR;
         ST_ERR:   state_in = ST_INC;
         ST_INC:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_INTEG;
         ST_INTEG: state_in = ST_SUM;
         ST_SUM:   state_in = ST_FIN;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_op   = '0;
      ld_err   = 1'b0;
      ld_acc   = 1'b0;
      ld_p1    = 1'b0;
      ld_sum   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_MEAS: begin
            mul_op.a = {{(MUL_W-16){delta_ff[15]}}, delta_ff};
            mul_op.b = {1'b0, regs.speed_scale};
         end
         ST_ERR: ld_err = 1'b1;
         ST_INC: begin
            mul_op.a = {err_ff[31], err_ff};
            mul_op.b = {{(MUL_W-16){1'b0}}, regs.sample_period};
         end
         ST_ACC: begin
            ld_acc   = 1'b1;
            mul_op.a = {err_ff[31], err_ff};
            mul_op.b = {1'b0, regs.prop_gain};
         end
         ST_INTEG: begin
            ld_p1    = 1'b1;
            mul_op.a = {integ_ff[31], integ_ff};
            mul_op.b = {1'b0, regs.integ_gain};
         end
         ST_SUM: ld_sum = 1'b1;
         ST_FIN: load_out = out_free;
         default: ;
      endcase
   end

   always_comb begin
      diff = $signed({{17{target_ff[31]}}, target_ff}) - $signed(prod[48:0]);
      if (diff[48:31] == '0 || diff[48:31] == '1) begin
         err_in = diff[31:0];
      end else if (diff[48]) begin
         err_in = 32'sh8000_0000;
      end else begin
         err_in = 32'sh7FFF_FFFF;
      end
   end

   always_comb begin
      inc_prod = prod[47:0];
      inc_adj  = inc_prod + (inc_prod[47] ? 48'sd65535 : 48'sd0);
      acc_sum  = $signed({{2{integ_ff[31]}}, integ_ff})
               + $signed({{2{inc_adj[47]}}, inc_adj[47:16]});
      lim      = $signed({3'b000, regs.integ_limit});
      if (acc_sum > lim) begin
         acc_clamp = lim;
      end else if (acc_sum < -lim) begin
         acc_clamp = -lim;
      end else begin
         acc_clamp = acc_sum;
      end
      integ_in = (target_ff == 32'sd0) ? 32'sd0 : acc_clamp[31:0];
   end

   always_comb begin
      adj_sum = sum_ff + (sum_ff[64] ? 65'sh7FFF_FFFF : 65'sd0);
      drive   = adj_sum[64:31];
      mag     = drive[33] ? 34'(-drive) : 34'(drive);
      sat     = (mag > 34'(DUTY_MAX));
      duty    = sat ? 16'(DUTY_MAX) : mag[15:0];
      result.load      = load_out;
      result.saturated = sat;
      result.duty_fwd  = (!drive[33] && drive != 34'sd0) ? duty : 16'd0;
      result.duty_rev  = drive[33] ? duty : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         integ_ff <= 32'sd0;
      end else begin
         state_ff <= state_in;
         if (ld_acc) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_in) begin
         target_ff <= target_speed;
         delta_ff  <= encoder_delta;
      end
      if (ld_err) begin
         err_ff <= err_in;
      end
      if (ld_p1) begin
         p1_ff <= halve(prod);
      end
      if (ld_sum) begin
         sum_ff <= p1_ff + halve(prod);
      end
   end

endmodule

FILE: rtl/pi_speed_loop_hbridge_pwm.sv
// ----------------------------------------------------------------------------
// PI speed loop with H-bridge PWM output
// Fixed-point PI speed controller with integral clamp and sign-magnitude split.
// ----------------------------------------------------------------------------
// Usage: each control tick the host sends one item on the req_ channel holding
// the target speed (signed Q16.16) and the encoder count delta. The block
// returns one item on the rsp_ channel with the forward and reverse compare
// values and a flag that marks a limited drive. Gains, the integral clamp,
// the speed scale and the sample period sit in registers on the csr_ port and
// are to be written while the block is idle; the block does not enforce this.
// An item runs through its steps in order: four products run in turn on one
// shared signed 33 x 33 multiplier with a registered output; the error step
// follows the first product, and the final sum and output steps follow the last.
// req_tready is high only while the sequencer is idle, so a new item is taken
// only once the previous one has left the sequencer.
// A result waits in an output register until taken; the next item is accepted
// meanwhile and holds in its last step if the previous result is still there.
// Reset clears the integral, loads the default register values and empties
// the output register.
// ----------------------------------------------------------------------------
module pi_speed_loop_hbridge_pwm #(
   parameter int unsigned DUTY_MAX = psl_pkg::DUTY_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,   // target_speed, encoder_delta
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // duty_fwd, duty_rev
   output logic                          rsp_tuser,   // drive_saturated
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [psl_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import psl_pkg::*;

   csr_regs_type             regs;
   mul_op_type               mul_op;
   logic signed [PROD_W-1:0] prod;
   psl_result_type           result;
   logic                     out_free;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [31:0]              rsp_data_ff;
   logic                     rsp_user_ff;

   psl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   psl_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod)
   );

   psl_seq #(
      .DUTY_MAX (DUTY_MAX)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .target_speed  (req_tdata[31:0]),
      .encoder_delta (req_tdata[47:32]),
      .out_free      (out_free),
      .regs          (regs),
      .mul_op        (mul_op),
      .prod          (prod),
      .result        (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_data_ff <= {result.duty_rev, result.duty_fwd};
         rsp_user_ff <= result.saturated;
      end
   end

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] == 16'd0 || rsp_tdata[31:16] == 16'd0))
      else $error("both compare values active");

   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[15:0] == 16'(DUTY_MAX) || rsp_tdata[31:16] == 16'(DUTY_MAX)))
      else $error("saturated drive below limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("pending result overwritten");

endmodule
